// File: design/salru_pkg.sv
`default_nettype none
package salru_pkg;

    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS     = 8;
    localparam int ADDR_WIDTH   = 64;

    localparam int NUM_SETS   = 1 << MAX_SET_BITS;
    localparam int SET_W      = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAYS_CNT_W = $clog2(MAX_WAYS + 1);

    // register fields, fixed by the register map
    localparam int SET_BITS_W   = 3;
    localparam int BLOCK_BITS_W = 5;
    localparam int WAYS_REG_W   = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 5;

    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 2'd2;

    localparam int FUNC_W = 2;
    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_STORE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MODIFY = 2'd2;

    localparam int OUTCOME_W = 2;
    localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_FILL  = 2'd1;
    localparam int CNT_W = 32;
    localparam logic [OUTCOME_W-1:0] OUT_EVICT = 2'd2;

    localparam int S_TDATA_W = ((ADDR_WIDTH + 7) / 8) * 8;
    localparam int M_BITS    = OUTCOME_W + 1 + 3 * CNT_W;
    localparam int M_TDATA_W = ((M_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic                    modify;
        logic [SET_W-1:0]        set_idx;
        logic [ADDR_WIDTH-1:0]   tag;
        logic [WAYS_CNT_W-1:0]   ways;
    } req_t;

endpackage
`default_nettype wire

// File: design/salru_front.sv
`default_nettype none
module salru_front (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    output      logic                             cfg_ready,
    input  wire logic [salru_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [salru_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                             s_tvalid,
    output      logic                             s_tready,
    input  wire logic [salru_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic [salru_pkg::FUNC_W-1:0]     s_tuser,
    output      logic                             q_push,
    output      salru_pkg::req_t                  q_data,
    input  wire logic                             q_full
);
    import salru_pkg::*;

    logic [SET_BITS_W-1:0]   set_bits_reg;
    logic [BLOCK_BITS_W-1:0] block_bits_reg;
    logic [WAYS_REG_W-1:0]   ways_reg;

    logic [SET_BITS_W-1:0]   sb;
    logic [WAYS_CNT_W-1:0]   eff_ways;
    logic [ADDR_WIDTH-1:0]   addr;
    logic [ADDR_WIDTH-1:0]   shifted;
    logic [SET_W-1:0]        set_mask;
    logic [BLOCK_BITS_W:0]   tag_shift;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_bits_reg   <= '0;
            block_bits_reg <= BLOCK_BITS_W'(4);
            ways_reg       <= WAYS_REG_W'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SET_BITS:   set_bits_reg   <= cfg_data[SET_BITS_W-1:0];
                REG_BLOCK_BITS: block_bits_reg <= cfg_data[BLOCK_BITS_W-1:0];
                REG_WAYS:       ways_reg       <= cfg_data[WAYS_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp the set_bits and ways registers to what the storage holds
    always_comb begin
        sb = (int'(set_bits_reg) > MAX_SET_BITS) ? SET_BITS_W'(MAX_SET_BITS) : set_bits_reg;
        if (ways_reg == '0) begin
            eff_ways = WAYS_CNT_W'(1);
        end else if (int'(ways_reg) > MAX_WAYS) begin
            eff_ways = WAYS_CNT_W'(MAX_WAYS);
        end else begin
            eff_ways = WAYS_CNT_W'(ways_reg);
        end
    end

    assign addr      = s_tdata[ADDR_WIDTH-1:0];
    assign shifted   = addr >> block_bits_reg;
    assign set_mask  = SET_W'((1 << sb) - 1);
    assign tag_shift = {1'b0, block_bits_reg} + (BLOCK_BITS_W + 1)'(sb);

    assign s_tready       = !q_full;
    assign q_push         = s_tvalid && !q_full;
    assign q_data.modify  = (s_tuser == FUNC_MODIFY);
    assign q_data.set_idx = shifted[SET_W-1:0] & set_mask;
    assign q_data.tag     = addr >> tag_shift;
    assign q_data.ways    = eff_ways;

endmodule
`default_nettype wire

// File: design/salru_queue.sv
`default_nettype none
module salru_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire salru_pkg::req_t push_data,
    output      logic            full,
    input  wire logic            pop,
    output      salru_pkg::req_t pop_data,
    output      logic            empty
);
    import salru_pkg::*;

    req_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule
`default_nettype wire

// File: design/salru_back.sv
`default_nettype none
module salru_back (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            q_empty,
    input  wire salru_pkg::req_t                 q_data,
    output      logic                            q_pop,
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    output      logic [salru_pkg::M_TDATA_W-1:0] m_tdata
);
    import salru_pkg::*;

    typedef enum logic {S_IDLE, S_EXEC} state_t;

    typedef struct packed {
        logic [MAX_WAYS-1:0]            valid;
        logic [MAX_WAYS-1:0][WAY_W-1:0] rank;
    } meta_t;

    typedef logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_row_t;

    tag_row_t tag_mem  [NUM_SETS];
    meta_t    meta_mem [NUM_SETS];

    state_t                 state_reg;
    req_t                   req_reg;
    tag_row_t               tag_row_reg;
    meta_t                  meta_row_reg;
    logic                   fresh_reg;
    logic [NUM_SETS-1:0]    written_reg;
    logic                   m_tvalid_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg;
    logic [CNT_W-1:0]       hits_reg;
    logic [CNT_W-1:0]       misses_reg;
    logic [CNT_W-1:0]       evicts_reg;

    logic                   mem_we;
    logic                   out_free;
    meta_t                  meta_cur;
    meta_t                  meta_new;
    tag_row_t               tag_row_new;
    logic [MAX_WAYS-1:0]    in_use;
    logic [MAX_WAYS-1:0]    match;
    logic                   hit;
    logic [WAY_W-1:0]       hit_way;
    logic                   has_empty;
    logic [WAY_W-1:0]       empty_way;
    logic                   have_victim;
    logic [WAY_W-1:0]       victim;
    logic [WAY_W-1:0]       vrank;
    logic [WAY_W-1:0]       sel_way;
    logic [WAY_W:0]         old_rank;
    logic [OUTCOME_W-1:0]   outcome;
    logic [1:0]             hit_inc;
    logic [CNT_W:0]         hits_sum;
    logic [CNT_W:0]         misses_sum;
    logic [CNT_W:0]         evicts_sum;
    logic [CNT_W-1:0]       hits_next;
    logic [CNT_W-1:0]       misses_next;
    logic [CNT_W-1:0]       evicts_next;

    assign q_pop    = (state_reg == S_IDLE) && !q_empty;
    assign out_free = !m_tvalid_reg || m_tready;
    assign mem_we   = (state_reg == S_EXEC) && out_free;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // a row never written reads as all ways empty
    assign meta_cur = fresh_reg ? meta_row_reg : '0;

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            tag_row_reg  <= tag_mem[q_data.set_idx];
            meta_row_reg <= meta_mem[q_data.set_idx];
        end
        if (mem_we) begin
            tag_mem[req_reg.set_idx]  <= tag_row_new;
            meta_mem[req_reg.set_idx] <= meta_new;
        end
    end

    always_comb begin
        hit         = 1'b0;
        hit_way     = '0;
        has_empty   = 1'b0;
        empty_way   = '0;
        have_victim = 1'b0;
        victim      = '0;
        vrank       = '0;
        for (int j = 0; j < MAX_WAYS; j++) begin
            in_use[j] = (WAYS_CNT_W'(j) < req_reg.ways);
            match[j]  = in_use[j] && meta_cur.valid[j] && (tag_row_reg[j] == req_reg.tag);
            if (match[j] && !hit) begin
                hit     = 1'b1;
                hit_way = WAY_W'(j);
            end
            if (in_use[j] && !meta_cur.valid[j] && !has_empty) begin
                has_empty = 1'b1;
                empty_way = WAY_W'(j);
            end
            if (in_use[j] && meta_cur.valid[j]
                    && (!have_victim || meta_cur.rank[j] > vrank)) begin
                have_victim = 1'b1;
                victim      = WAY_W'(j);
                vrank       = meta_cur.rank[j];
            end
        end

        // a fill ages every valid in-use way below the top rank, as if it came from below the oldest
        if (hit) begin
            sel_way  = hit_way;
            old_rank = {1'b0, meta_cur.rank[hit_way]};
            outcome  = OUT_HIT;
        end else if (has_empty) begin
            sel_way  = empty_way;
            old_rank = (WAY_W + 1)'(MAX_WAYS);
            outcome  = OUT_FILL;
        end else begin
            sel_way  = victim;
            old_rank = {1'b0, vrank};
            outcome  = OUT_EVICT;
        end

        tag_row_new = tag_row_reg;
        tag_row_new[sel_way] = req_reg.tag;
        meta_new = meta_cur;
        meta_new.valid[sel_way] = 1'b1;
        for (int j = 0; j < MAX_WAYS; j++) begin
            if (WAY_W'(j) == sel_way) begin
                meta_new.rank[j] = '0;
            end else if (in_use[j] && meta_cur.valid[j]
                    && ({1'b0, meta_cur.rank[j]} < old_rank)
                    && (meta_cur.rank[j] != WAY_W'(MAX_WAYS - 1))) begin
                meta_new.rank[j] = meta_cur.rank[j] + WAY_W'(1);
            end
        end

        // the second access of a modify always hits
        hit_inc     = 2'(hit) + 2'(req_reg.modify);
        hits_sum    = {1'b0, hits_reg} + (CNT_W + 1)'(hit_inc);
        misses_sum  = {1'b0, misses_reg} + (CNT_W + 1)'(!hit);
        evicts_sum  = {1'b0, evicts_reg} + (CNT_W + 1)'(outcome == OUT_EVICT);
        hits_next   = hits_sum[CNT_W]   ? '1 : hits_sum[CNT_W-1:0];
        misses_next = misses_sum[CNT_W] ? '1 : misses_sum[CNT_W-1:0];
        evicts_next = evicts_sum[CNT_W] ? '1 : evicts_sum[CNT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            req_reg   <= q_data;
            fresh_reg <= written_reg[q_data.set_idx];
        end
        if (mem_we) begin
            m_tdata_reg <= M_TDATA_W'({evicts_next, misses_next, hits_next,
                                       req_reg.modify, outcome});
        end
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            written_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            hits_reg     <= '0;
            misses_reg   <= '0;
            evicts_reg   <= '0;
        end else begin
            if (mem_we) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_pop) begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (mem_we) begin
                        written_reg[req_reg.set_idx] <= 1'b1;
                        hits_reg     <= hits_next;
                        misses_reg   <= misses_next;
                        evicts_reg   <= evicts_next;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: design/set_assoc_cache_lru_sim.sv
`default_nettype none
// A result word is registered after its access passes the queue, then the request and row
// registers; back-pressure on m_tready can hold it. The next access waits for the read then
// write-back of a set's row (tags, valid bits, ranks) through the single-port row memories.
// A 2-entry queue between decode and execution keeps input flowing while a result waits.
// Reset (aresetn low, synchronous): registers return to set_bits 0, block_bits 4,
// ways 1; totals clear; per-set written flags clear, so every set starts empty.
module set_assoc_cache_lru_sim (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    output      logic                             cfg_ready,
    input  wire logic [salru_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [salru_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                             s_tvalid,
    output      logic                             s_tready,
    input  wire logic [salru_pkg::S_TDATA_W-1:0]  s_tdata,  // address
    input  wire logic [salru_pkg::FUNC_W-1:0]     s_tuser,  // func
    output      logic                             m_tvalid,
    input  wire logic                             m_tready,
    // outcome, extra_hit, hits_total, misses_total, evictions_total, zero pad
    output      logic [salru_pkg::M_TDATA_W-1:0]  m_tdata
);
    import salru_pkg::*;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    req_t q_wr_data;
    req_t q_rd_data;

    salru_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_push    (q_push),
        .q_data    (q_wr_data),
        .q_full    (q_full)
    );

    salru_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wr_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rd_data),
        .empty     (q_empty)
    );

    salru_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_data   (q_rd_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire
